### rtl/spq_pkg.sv
// Shared types, sizes and helpers for the stable priority queue.
package spq_pkg;

  localparam int CAPACITY      = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int TAG_BITS      = 32;
  localparam int IDX_W         = $clog2(CAPACITY);
  localparam int CNT_W         = $clog2(CAPACITY + 1);

  typedef enum logic [0:0] {
    FUNC_INSERT = 1'b0,
    FUNC_SERVE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_TAIL = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_t;

  typedef enum logic [0:0] {
    WR_SHIFT = 1'b0,
    WR_NEW   = 1'b1
  } wr_sel_t;

  typedef struct packed {
    func_t                    func;
    logic [PRIORITY_BITS-1:0] new_priority;
    logic [TAG_BITS-1:0]      new_tag;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic [PRIORITY_BITS-1:0] served_priority;
    logic [TAG_BITS-1:0]      served_tag;
    logic [CNT_W-1:0]         occupancy;
  } out_item_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [TAG_BITS-1:0]      tag;
  } entry_t;

  typedef struct packed {
    logic    capture;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    step;
    logic    cnt_inc;
    logic    serve_pop;
    logic    res_load;
    status_t res_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic j_zero;
    logic less;
  } dp_status_t;

  function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(CAPACITY)) begin
      sum = sum - (IDX_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### rtl/spq_dpath.sv
// Datapath of the priority queue: ring buffer memory, pointers and result register.
module spq_dpath (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::ctrl_cmd_t cmd,
  input  spq_pkg::in_item_t  in_item,
  output spq_pkg::dp_status_t sts,
  output spq_pkg::out_item_t out_item
);
  import spq_pkg::*;

  entry_t                   mem [CAPACITY];
  entry_t                   rdata;
  entry_t                   wdata;
  logic [IDX_W-1:0]         head;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [CNT_W-1:0]         j;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic [TAG_BITS-1:0]      new_tag;
  out_item_t                res;
  logic [CNT_W-1:0]         cnt_m1;
  logic [CNT_W-1:0]         j_m1;
  logic [CNT_W-1:0]         j_p1;
  logic [CNT_W-1:0]         rd_off;
  logic [IDX_W-1:0]         raddr;
  logic [IDX_W-1:0]         waddr;

  assign cnt_m1 = count - CNT_W'(1);
  assign j_m1   = j - CNT_W'(1);
  assign j_p1   = j + CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD: rd_off = '0;
      RD_TAIL: rd_off = cnt_m1;
      RD_NEXT: rd_off = j_m1;
      default: rd_off = '0;
    endcase
  end

  assign raddr = slot_addr(head, rd_off[IDX_W-1:0]);
  assign waddr = slot_addr(head, j_p1[IDX_W-1:0]);

  always_comb begin
    case (cmd.wr_sel)
      WR_SHIFT: wdata = rdata;
      WR_NEW:   wdata = '{prio: new_prio, tag: new_tag};
      default:  wdata = rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    count_next = count;
    if (cmd.cnt_inc) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.serve_pop) begin
      count_next = cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (cmd.serve_pop) begin
        head <= slot_addr(head, IDX_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      new_prio <= in_item.new_priority;
      new_tag  <= in_item.new_tag;
      j        <= cnt_m1;
    end else if (cmd.step) begin
      j <= j_m1;
    end
    if (cmd.res_load) begin
      res.status          <= cmd.res_status;
      res.served_priority <= cmd.serve_pop ? rdata.prio : '0;
      res.served_tag      <= cmd.serve_pop ? rdata.tag : '0;
      res.occupancy       <= count_next;
    end
  end

  assign sts.count_zero = (count == '0);
  assign sts.count_full = (count == CNT_W'(CAPACITY));
  assign sts.j_zero     = (j == '0);
  assign sts.less       = (rdata.prio < new_prio);
  assign out_item       = res;

endmodule

### rtl/spq_ctrl.sv
// Controller state machine that sequences inserts and serves of the priority queue.
module spq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  spq_pkg::func_t      in_func,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  spq_pkg::dp_status_t sts,
  output spq_pkg::ctrl_cmd_t  cmd
);
  import spq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_PLACE = 4'b0100,
    S_SERVE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.rd_sel     = RD_HEAD;
    cmd.wr_sel     = WR_NEW;
    cmd.res_status = ST_DONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_INSERT) begin
            if (sts.count_full) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_FULL;
            end else begin
              cmd.capture = 1'b1;
              cmd.rd_sel  = RD_TAIL;
              state_next  = sts.count_zero ? S_PLACE : S_SCAN;
            end
          end else begin
            if (sts.count_zero) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.rd_sel = RD_HEAD;
              state_next = S_SERVE;
            end
          end
        end
      end
      S_SCAN: begin
        cmd.wr_en = 1'b1;
        if (sts.less) begin
          cmd.wr_sel = WR_SHIFT;
          cmd.step   = 1'b1;
          cmd.rd_sel = RD_NEXT;
          if (sts.j_zero) begin
            state_next = S_PLACE;
          end
        end else begin
          cmd.wr_sel   = WR_NEW;
          cmd.cnt_inc  = 1'b1;
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_PLACE: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = WR_NEW;
        cmd.cnt_inc  = 1'b1;
        cmd.res_load = 1'b1;
        state_next   = S_IDLE;
      end
      S_SERVE: begin
        cmd.serve_pop = 1'b1;
        cmd.res_load  = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("Result loaded while an earlier transaction is still pending.");

  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !out_valid)
    else $error("Result pending while an operation is in progress.");

  a_scan_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !sts.less) |=> (state == S_IDLE && out_valid))
    else $error("Insert scan did not complete with a result.");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !sts.count_full)
    else $error("Entry count incremented on a full queue.");
`endif

endmodule

### rtl/stable_priority_queue.sv
// Top level of the bounded stable priority queue with sorted insert.
//
//   Channel  Valid      Ready      Payload
//   input    in_valid   in_ready   in_data  (func, new_priority, new_tag)
//   output   out_valid  out_ready  out_data (status, served_priority, served_tag, occupancy)
//
// A refused insert or a serve on an empty queue gives its result in the cycle after acceptance.
// A serve reads the head entry, then loads the result; an insert walks the ring memory from
// the tail one entry per cycle, moving back lower-priority entries, then writes the new one.
// One transaction is in progress at a time; a new one is taken when the result register is
// empty or being read. Reset empties the queue at once; the entry memory is not cleared.
module stable_priority_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  spq_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output spq_pkg::out_item_t  out_data
);
  import spq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spq_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_data),
    .sts      (sts),
    .out_item (out_data)
  );

endmodule

### dv/testbench.sv
// Self-checking testbench for the bounded stable priority queue.
`timescale 1ns / 100ps

module testbench;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  pending_ops[$];
  out_item_t expected_results[$];
  entry_t    queue_slots[CAPACITY];
  int        queue_depth  = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        error_count  = 0;
  int        cycle_count  = 0;

  stable_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_item_t apply_queue_op(input in_item_t op);
    out_item_t res;
    int        pos;
    int        i;
    res = '0;
    res.status = ST_DONE;
    if (op.func == FUNC_INSERT) begin
      if (queue_depth >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < queue_depth && queue_slots[pos].prio >= op.new_priority) begin
          pos++;
        end
        for (i = queue_depth; i > pos; i--) begin
          queue_slots[i] = queue_slots[i - 1];
        end
        queue_slots[pos].prio = op.new_priority;
        queue_slots[pos].tag  = op.new_tag;
        queue_depth++;
      end
    end else if (queue_depth == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.served_priority = queue_slots[0].prio;
      res.served_tag      = queue_slots[0].tag;
      for (i = 1; i < queue_depth; i++) begin
        queue_slots[i - 1] = queue_slots[i];
      end
      queue_depth--;
    end
    res.occupancy = CNT_W'(queue_depth);
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_queue_op(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result transaction with no expectation pending");
      end else begin
        want = expected_results.pop_front();
        if (out_data.status != want.status) begin
          note_mismatch($sformatf("status got %0d want %0d", out_data.status, want.status));
        end
        if (out_data.served_priority != want.served_priority) begin
          note_mismatch($sformatf("served_priority got %0d want %0d",
                                  out_data.served_priority, want.served_priority));
        end
        if (out_data.served_tag != want.served_tag) begin
          note_mismatch($sformatf("served_tag got %h want %h",
                                  out_data.served_tag, want.served_tag));
        end
        if (out_data.occupancy != want.occupancy) begin
          note_mismatch($sformatf("occupancy got %0d want %0d",
                                  out_data.occupancy, want.occupancy));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic add_op(input func_t f, input int prio, input logic [TAG_BITS-1:0] tag);
    in_item_t op;
    op.func         = f;
    op.new_priority = PRIORITY_BITS'(prio);
    op.new_tag      = tag;
    pending_ops.push_back(op);
  endtask

  task automatic add_random_ops(input int total);
    in_item_t op;
    func_t    kind;
    int       burst;
    bit       narrow;
    int       k;
    k = 0;
    while (k < total) begin
      burst  = $urandom_range(1, 20);
      narrow = ($urandom_range(1) == 0);
      kind   = $urandom_range(1) ? FUNC_SERVE : FUNC_INSERT;
      repeat (burst) begin
        if ($urandom_range(9) == 0) begin
          op.func = (kind == FUNC_INSERT) ? FUNC_SERVE : FUNC_INSERT;
        end else begin
          op.func = kind;
        end
        op.new_priority = narrow ? PRIORITY_BITS'($urandom_range(3))
                                 : PRIORITY_BITS'($urandom_range(255));
        op.new_tag      = TAG_BITS'($urandom);
        pending_ops.push_back(op);
        k++;
      end
    end
  endtask

  task automatic wait_for_quiet();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    int i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_op(FUNC_SERVE, 255, 32'hFFFF_FFFF);
    add_op(FUNC_INSERT, 255, 32'hFFFF_FFFF);
    add_op(FUNC_INSERT, 0, 32'h0000_0000);
    add_op(FUNC_INSERT, 128, 32'hA5A5_0001);
    add_op(FUNC_INSERT, 128, 32'hA5A5_0002);
    add_op(FUNC_INSERT, 128, 32'hA5A5_0003);
    for (i = 0; i < 11; i++) begin
      add_op(FUNC_INSERT, (i * 53) % 256, 32'h5A5A_0000 + i);
    end
    add_op(FUNC_INSERT, 200, 32'h1234_5678);
    for (i = 0; i < 5; i++) begin
      add_op(FUNC_SERVE, 0, 32'h0);
    end
    add_random_ops(160);
    wait_for_quiet();

    send_idle_pct  = 87;
    recv_stall_pct = 0;
    add_random_ops(160);
    wait_for_quiet();

    send_idle_pct  = 0;
    recv_stall_pct = 87;
    add_random_ops(160);
    wait_for_quiet();

    send_idle_pct  = 27;
    recv_stall_pct = 27;
    add_random_ops(160);
    wait_for_quiet();

    repeat (2 * CAPACITY + 8) @(posedge clk);
    if (expected_results.size() != 0) begin
      note_mismatch("expected results left over at end of run");
    end
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/spq_pkg.sv
rtl/spq_dpath.sv
rtl/spq_ctrl.sv
rtl/stable_priority_queue.sv
dv/testbench.sv
